FILE: rtl/ecp_pkg.sv
// ----------------------------------------------------------------------------
// ecp_pkg
// Shared types and constants of the encoder frame position corrector.
// ----------------------------------------------------------------------------
package ecp_pkg;

  localparam int POS_W      = 13;
  localparam int DEV_W      = 6;
  localparam int TEMP_W     = 13;
  localparam int TVAL_W     = 16;
  localparam int TADDR_W    = 8;
  localparam int TBL_DEPTH  = 256;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;

  localparam logic       KIND_BYTE  = 1'b0;
  localparam logic       KIND_TABLE = 1'b1;

  localparam logic       FT_DEVICE   = 1'b0;
  localparam logic       FT_POSITION = 1'b1;

  localparam logic [1:0] SYNC_DEVICE = 2'b10;

  localparam logic [CFG_IDX_W-1:0] CFG_ZERO_OFFSET = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_REVERSE     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TABLE_EN    = 2'd2;

  typedef struct packed {
    logic              frame_type;
    logic [DEV_W-1:0]  device_code;
    logic [TEMP_W-1:0] temperature;
    logic [POS_W-1:0]  position_reversed;
    logic [POS_W-1:0]  position;
    logic              data_valid;
  } rec_t;

endpackage

FILE: rtl/ecp_if.sv
// ----------------------------------------------------------------------------
// ecp_if
// Valid/ready channels of the encoder frame position corrector.
// ----------------------------------------------------------------------------
interface ecp_in_if;
  import ecp_pkg::*;

  logic                     valid;
  logic                     ready;
  logic                     kind;
  logic [7:0]               rx_byte;
  logic [TADDR_W-1:0]       table_index;
  logic signed [TVAL_W-1:0] table_value;

  modport source (output valid, kind, rx_byte, table_index, table_value, input ready);
  modport sink   (input valid, kind, rx_byte, table_index, table_value, output ready);
endinterface

interface ecp_out_if;
  import ecp_pkg::*;

  logic              valid;
  logic              ready;
  logic              frame_type;
  logic [DEV_W-1:0]  device_code;
  logic [TEMP_W-1:0] temperature;
  logic [POS_W-1:0]  position_reversed;
  logic [POS_W-1:0]  position;
  logic              data_valid;

  modport source (output valid, frame_type, device_code, temperature, position_reversed,
                  position, data_valid, input ready);
  modport sink   (input valid, frame_type, device_code, temperature, position_reversed,
                  position, data_valid, output ready);
endinterface

FILE: rtl/ecp_corr_table.sv
// ----------------------------------------------------------------------------
// ecp_corr_table
// Correction table memory: one write port, two registered read ports.
// ----------------------------------------------------------------------------
module ecp_corr_table (
  input  logic                              clk,
  input  logic                              we,
  input  logic [ecp_pkg::TADDR_W-1:0]       waddr,
  input  logic signed [ecp_pkg::TVAL_W-1:0] wdata,
  input  logic                              re,
  input  logic [ecp_pkg::TADDR_W-1:0]       raddr0,
  input  logic [ecp_pkg::TADDR_W-1:0]       raddr1,
  output logic signed [ecp_pkg::TVAL_W-1:0] rdata0,
  output logic signed [ecp_pkg::TVAL_W-1:0] rdata1
);
  import ecp_pkg::*;

  logic signed [TVAL_W-1:0] mem [TBL_DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata0 <= mem[raddr0];
      rdata1 <= mem[raddr1];
    end
  end

endmodule

FILE: rtl/ecp_frame_dec.sv
// ----------------------------------------------------------------------------
// ecp_frame_dec
// Link byte framing, field registers, reversal and zero offset.
// ----------------------------------------------------------------------------
module ecp_frame_dec #(
  parameter int POSITION_BITS = 13
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            en,
  input  logic [7:0]                      rx_byte,
  input  logic [ecp_pkg::CFG_DATA_W-1:0]  zero_offset,
  input  logic                            reverse_enable,
  output logic                            done,
  output ecp_pkg::rec_t                   rec
);
  import ecp_pkg::*;

  logic [1:0]        phase_r, phase_nxt;
  logic              open_r, open_nxt;
  logic [7:0]        h0_r, h0_nxt, h1_r, h1_nxt, h2_r, h2_nxt;
  logic [DEV_W-1:0]  dev_r, dev_nxt;
  logic [TEMP_W-1:0] temp_r, temp_nxt;
  logic [13:0]       pos_r, pos_nxt;
  logic              valid_r, valid_nxt;
  logic              ftype;
  logic [POSITION_BITS-1:0] pos_m, pos_rev, pos_off;

  always_comb begin
    phase_nxt = phase_r;
    open_nxt  = open_r;
    h0_nxt    = h0_r;
    h1_nxt    = h1_r;
    h2_nxt    = h2_r;
    dev_nxt   = dev_r;
    temp_nxt  = temp_r;
    pos_nxt   = pos_r;
    valid_nxt = valid_r;
    done      = 1'b0;
    ftype     = FT_POSITION;
    if (rx_byte[7]) begin
      h0_nxt    = rx_byte;
      open_nxt  = 1'b1;
      phase_nxt = 2'd0;
    end else if (open_r) begin
      if (phase_r < 2'd2) begin
        phase_nxt = phase_r + 2'd1;
        if (phase_r == 2'd0) begin
          h1_nxt = rx_byte;
        end else begin
          h2_nxt = rx_byte;
        end
      end else begin
        open_nxt  = 1'b0;
        phase_nxt = 2'd0;
        done      = 1'b1;
        valid_nxt = 1'b1;
        if (h0_r[7:6] == SYNC_DEVICE) begin
          dev_nxt = h0_r[5:0];
          ftype   = FT_DEVICE;
        end else begin
          temp_nxt = {h0_r[5:0], h1_r[6:0]};
          pos_nxt  = {h2_r[6:0], rx_byte[6:0]};
          ftype    = FT_POSITION;
        end
      end
    end
  end

  assign pos_m   = pos_nxt[POSITION_BITS-1:0];
  assign pos_rev = reverse_enable ? (POSITION_BITS'(0) - pos_m) : pos_m;
  assign pos_off = pos_rev - zero_offset[POSITION_BITS-1:0];

  always_comb begin
    rec.frame_type        = ftype;
    rec.device_code       = dev_nxt;
    rec.temperature       = temp_nxt;
    rec.position_reversed = POS_W'(pos_rev);
    rec.position          = POS_W'(pos_off);
    rec.data_valid        = valid_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= 2'd0;
      open_r  <= 1'b0;
      h0_r    <= '0;
      h1_r    <= '0;
      h2_r    <= '0;
      dev_r   <= '0;
      temp_r  <= '0;
      pos_r   <= '0;
      valid_r <= 1'b0;
    end else if (en) begin
      phase_r <= phase_nxt;
      open_r  <= open_nxt;
      h0_r    <= h0_nxt;
      h1_r    <= h1_nxt;
      h2_r    <= h2_nxt;
      dev_r   <= dev_nxt;
      temp_r  <= temp_nxt;
      pos_r   <= pos_nxt;
      valid_r <= valid_nxt;
    end
  end

endmodule

FILE: rtl/ecp_interp.sv
// ----------------------------------------------------------------------------
// ecp_interp
// Table interpolation pipeline and output register.
// ----------------------------------------------------------------------------
module ecp_interp #(
  parameter int POSITION_BITS = 13
) (
  input  logic                              clk,
  input  logic                              rst_n,
  output logic                              advance,
  input  logic                              s0_valid,
  input  ecp_pkg::rec_t                     s0_rec,
  input  logic                              table_enable,
  input  logic signed [ecp_pkg::TVAL_W-1:0] rd0,
  input  logic signed [ecp_pkg::TVAL_W-1:0] rd1,
  ecp_out_if.source                         out_bus
);
  import ecp_pkg::*;

  localparam int FRAC_BITS = POSITION_BITS - 8;
  localparam int FRAC_W    = (FRAC_BITS > 0) ? FRAC_BITS : 1;
  localparam int PROD_W    = TVAL_W + 1 + FRAC_W + 1;

  logic                       v1_r, v2_r, ov_r;
  rec_t                       rec1_r, rec2_r, orec_r;
  logic signed [TVAL_W:0]     diff;
  logic [FRAC_W-1:0]          frac;
  logic signed [PROD_W-1:0]   prod, prod_r, shifted;
  logic signed [TVAL_W-1:0]   o0_r;
  logic [POSITION_BITS-1:0]   interp, pos_cor;
  rec_t                       rec2_fin;

  assign advance = !ov_r || out_bus.ready;

  assign diff = {rd1[TVAL_W-1], rd1} - {rd0[TVAL_W-1], rd0};
  assign frac = (FRAC_BITS > 0) ? rec1_r.position[FRAC_W-1:0] : '0;
  assign prod = PROD_W'(diff) * PROD_W'(signed'({1'b0, frac}));

  assign shifted = prod_r >>> FRAC_BITS;
  assign interp  = o0_r[POSITION_BITS-1:0] + shifted[POSITION_BITS-1:0];
  assign pos_cor = rec2_r.position[POSITION_BITS-1:0] + interp;

  always_comb begin
    rec2_fin = rec2_r;
    if (table_enable) begin
      rec2_fin.position = POS_W'(pos_cor);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      ov_r <= 1'b0;
    end else if (advance) begin
      v1_r <= s0_valid;
      v2_r <= v1_r;
      ov_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      rec1_r <= s0_rec;
      rec2_r <= rec1_r;
      o0_r   <= rd0;
      prod_r <= prod;
      orec_r <= rec2_fin;
    end
  end

  assign out_bus.valid             = ov_r;
  assign out_bus.frame_type        = orec_r.frame_type;
  assign out_bus.device_code       = orec_r.device_code;
  assign out_bus.temperature       = orec_r.temperature;
  assign out_bus.position_reversed = orec_r.position_reversed;
  assign out_bus.position          = orec_r.position;
  assign out_bus.data_valid        = orec_r.data_valid;

endmodule

FILE: rtl/encoder_frame_position_corrector.sv
// ----------------------------------------------------------------------------
// encoder_frame_position_corrector
// Decodes encoder link frames and, when the table is enabled, corrects
// the position through a linearly interpolated table.
//
//   Channel   Direction  Beat contents
//   in_bus    input      kind, rx_byte, table_index, table_value
//   out_bus   output     frame_type, device_code, temperature,
//                        position_reversed, position, data_valid
//   cfg_*     input      cfg_we, cfg_index, cfg_wdata
//
// One beat is accepted per cycle while in_bus.ready is high. A completed
// frame's result passes through the table read register, the interpolation
// multiply register and the output register. Reset clears the framing state,
// the field registers and the configuration registers; the table is not
// cleared. When the output holds a beat that is not taken, the whole
// pipeline and in_bus.ready hold.
// ----------------------------------------------------------------------------
module encoder_frame_position_corrector #(
  parameter int POSITION_BITS = 13
) (
  input  logic                             clk,
  input  logic                             rst_n,
  ecp_in_if.sink                           in_bus,
  ecp_out_if.source                        out_bus,
  input  logic                             cfg_we,
  input  logic [ecp_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [ecp_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
  import ecp_pkg::*;

  logic [CFG_DATA_W-1:0]    zero_offset_r;
  logic                     reverse_r;
  logic                     table_en_r;
  logic                     advance;
  logic                     accept;
  logic                     byte_en;
  logic                     done;
  rec_t                     rec;
  logic [TADDR_W-1:0]       idx;
  logic signed [TVAL_W-1:0] rd0, rd1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      zero_offset_r <= '0;
      reverse_r     <= 1'b0;
      table_en_r    <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ZERO_OFFSET: zero_offset_r <= cfg_wdata;
        CFG_REVERSE:     reverse_r     <= cfg_wdata[0];
        CFG_TABLE_EN:    table_en_r    <= cfg_wdata[0];
        default: begin
        end
      endcase
    end
  end

  assign in_bus.ready = advance;
  assign accept       = in_bus.valid && advance;
  assign byte_en      = accept && (in_bus.kind == KIND_BYTE);

  ecp_frame_dec #(
    .POSITION_BITS (POSITION_BITS)
  ) u_dec (
    .clk            (clk),
    .rst_n          (rst_n),
    .en             (byte_en),
    .rx_byte        (in_bus.rx_byte),
    .zero_offset    (zero_offset_r),
    .reverse_enable (reverse_r),
    .done           (done),
    .rec            (rec)
  );

  assign idx = rec.position[POSITION_BITS-1 -: TADDR_W];

  ecp_corr_table u_tbl (
    .clk    (clk),
    .we     (accept && (in_bus.kind == KIND_TABLE)),
    .waddr  (in_bus.table_index),
    .wdata  (in_bus.table_value),
    .re     (advance),
    .raddr0 (idx),
    .raddr1 (idx + TADDR_W'(1)),
    .rdata0 (rd0),
    .rdata1 (rd1)
  );

  ecp_interp #(
    .POSITION_BITS (POSITION_BITS)
  ) u_interp (
    .clk          (clk),
    .rst_n        (rst_n),
    .advance      (advance),
    .s0_valid     (byte_en && done),
    .s0_rec       (rec),
    .table_enable (table_en_r),
    .rd0          (rd0),
    .rd1          (rd1),
    .out_bus      (out_bus)
  );

endmodule
